FILE: rtl/chr_pkg.sv
`default_nettype none

package chr_pkg;

    // Item field widths
    localparam int KEY_W  = 64;
    localparam int MODE_W = 2;
    localparam int SLOT_W = 5;

    // Operation codes carried on the input side
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

    // Source of the result fields
    typedef enum logic [1:0] {
        RES_ECHO,
        RES_HIT,
        RES_MISS
    } chr_res_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic         load;
        logic         clr_step;
        logic         wr_slot;
        logic         scan_start;
        logic         scan_read;
        logic         res_capture;
        chr_res_sel_t res_sel;
        logic         out_load;
    } chr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic              mod_busy;
        logic              clr_last;
        logic              scan_hit;
        logic              scan_done;
        logic              out_free;
        logic [MODE_W-1:0] mode;
    } chr_status_t;

endpackage

`default_nettype wire

FILE: rtl/consistent_hash_ring_core.sv
// Consistent-hashing ring with RING_SIZE slots.
// Input channel s_: s_tuser carries the mode (add, remove, look up), s_tdata the
// 64-bit key. Each item produces exactly one result item on m_: m_tdata holds the
// server id and the slot (the key's ring position, low 5 bits), m_tuser the found flag.
// The key is hashed by a 64-bit xorshift and reduced modulo RING_SIZE in a pipelined
// unit (weighted sum of 16-bit chunks, reciprocal quotient, one correction).
// Add and remove: once the position is ready the slot is written and the result held;
// it moves into the output register as soon as that register is free.
// Lookup: the ring memory is read one slot per cycle from the hashed position,
// stopping at the first valid slot, so 1 to RING_SIZE slots are visited.
// One item is worked on at a time; the next item is accepted from the cycle after the
// previous result has moved into the output register, even while that result is stalled.
// When the receiver holds m_tready low, the result stays in the output register
// and a following result waits until it is taken.
// After reset the ring memory is swept invalid, one slot per cycle, through all RING_SIZE
// slots; s_tready stays low during the sweep and the ring then starts empty.
`default_nettype none

module consistent_hash_ring_core
    import chr_pkg::*;
#(
    parameter int RING_SIZE = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [63:0] key
    input  wire  [1:0]  s_tuser,   // [1:0] mode
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // [63:0] server_id, [68:64] slot, [71:69] zero
    output logic        m_tuser    // [0] found
);

    chr_cmd_t            cmd;
    chr_status_t         status;
    logic [KEY_W-1:0]    out_server;
    logic [SLOT_W-1:0]   out_slot;

    chr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    chr_dp #(
        .RING_SIZE (RING_SIZE)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .status     (status),
        .in_mode    (s_tuser),
        .in_key     (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_server (out_server),
        .out_found  (m_tuser),
        .out_slot   (out_slot)
    );

    // Pack the result fields
    assign m_tdata = {3'b000, out_slot, out_server};

endmodule

`default_nettype wire

FILE: rtl/chr_posmod.sv
`default_nettype none

module chr_posmod
    import chr_pkg::*;
#(
    parameter int RING_SIZE = 32
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           start,
    input  wire  [KEY_W-1:0]              hash_in,
    output logic                          busy,
    output logic [$clog2(RING_SIZE)-1:0]  pos
);

    localparam int IDX_W   = $clog2(RING_SIZE);
    localparam int CHUNK_W = 16;
    localparam int SUM_W   = CHUNK_W + IDX_W + 2;
    localparam int STEPS   = 3;
    localparam int STEP_W  = $clog2(STEPS);

    // Residue of each 16-bit chunk weight 2^(16k) modulo the ring size
    localparam logic [SUM_W-1:0] WEIGHT_0 = SUM_W'(64'd1 % 64'(RING_SIZE));
    localparam logic [SUM_W-1:0] WEIGHT_1 = SUM_W'((64'd1 << CHUNK_W) % 64'(RING_SIZE));
    localparam logic [SUM_W-1:0] WEIGHT_2 =
        SUM_W'((64'd1 << (2 * CHUNK_W)) % 64'(RING_SIZE));
    localparam logic [SUM_W-1:0] WEIGHT_3 =
        SUM_W'((64'd1 << (3 * CHUNK_W)) % 64'(RING_SIZE));

    // Scaled reciprocal; the quotient it gives is short by at most one
    localparam logic [SUM_W-1:0] RECIP  = SUM_W'((64'd1 << SUM_W) / 64'(RING_SIZE));
    localparam logic [SUM_W-1:0] RING_N = SUM_W'(RING_SIZE);
    localparam logic [IDX_W:0]   RING_R = (IDX_W + 1)'(RING_SIZE);

    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   quot_reg;
    logic [IDX_W:0]     rem_reg;
    logic [IDX_W-1:0]   pos_reg;
    logic [STEP_W-1:0]  cnt_reg;
    logic               busy_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [2*SUM_W-1:0] prod;
    logic [SUM_W-1:0]   back;
    logic [SUM_W-1:0]   diff;
    logic [IDX_W:0]     rem_fix;

    // Fold the hash to a small sum with the same residue, then divide by reciprocal
    always_comb begin
        sum_next = SUM_W'(hash_in[CHUNK_W-1:0]) * WEIGHT_0
                 + SUM_W'(hash_in[2*CHUNK_W-1:CHUNK_W]) * WEIGHT_1
                 + SUM_W'(hash_in[3*CHUNK_W-1:2*CHUNK_W]) * WEIGHT_2
                 + SUM_W'(hash_in[4*CHUNK_W-1:3*CHUNK_W]) * WEIGHT_3;
        prod     = (2 * SUM_W)'(sum_reg) * (2 * SUM_W)'(RECIP);
        back     = quot_reg * RING_N;
        diff     = sum_reg - back;
        rem_fix  = (rem_reg >= RING_R) ? rem_reg - RING_R : rem_reg;
    end

    // Count the pipeline steps after start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Advance sum, quotient, remainder and position; hold once done
    always_ff @(posedge aclk) begin
        if (start) begin
            sum_reg <= sum_next;
        end
        if (busy_reg) begin
            quot_reg <= prod[2*SUM_W-1:SUM_W];
            rem_reg  <= diff[IDX_W:0];
            pos_reg  <= rem_fix[IDX_W-1:0];
        end
    end

    assign busy = busy_reg;
    assign pos  = pos_reg;

endmodule

`default_nettype wire

FILE: rtl/chr_dp.sv
`default_nettype none

module chr_dp
    import chr_pkg::*;
#(
    parameter int RING_SIZE = 32
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  chr_cmd_t              cmd,
    output chr_status_t           status,
    input  wire  [MODE_W-1:0]     in_mode,
    input  wire  [KEY_W-1:0]      in_key,
    input  wire                   out_ready,
    output logic                  out_valid,
    output logic [KEY_W-1:0]      out_server,
    output logic                  out_found,
    output logic [SLOT_W-1:0]     out_slot
);

    localparam int IDX_W = $clog2(RING_SIZE);
    localparam int CNT_W = $clog2(RING_SIZE + 1);

    logic [KEY_W:0]      ring_mem [RING_SIZE];

    logic [KEY_W-1:0]    key_reg;
    logic [MODE_W-1:0]   mode_reg;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic [IDX_W-1:0]    scan_addr_reg;
    logic [CNT_W-1:0]    scan_cnt_reg;
    logic [KEY_W:0]      rd_data_reg;
    logic                rd_vld_reg;
    logic [KEY_W-1:0]    res_server_reg;
    logic                res_found_reg;
    logic                m_valid_reg;
    logic [KEY_W-1:0]    m_server_reg;
    logic                m_found_reg;
    logic [SLOT_W-1:0]   m_slot_reg;

    logic [IDX_W-1:0]    pos;
    logic                mod_busy;
    logic [31:0]         pos_wide;
    logic [IDX_W-1:0]    wr_addr;
    logic [KEY_W:0]      wr_data;
    logic                wr_en;

    function automatic logic [KEY_W-1:0] ring_hash(input logic [KEY_W-1:0] v);
        logic [KEY_W-1:0] x;
        x = v ^ (v << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // Reduce the hash to a ring position
    chr_posmod #(
        .RING_SIZE (RING_SIZE)
    ) u_posmod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.load),
        .hash_in (ring_hash(in_key)),
        .busy    (mod_busy),
        .pos     (pos)
    );

    // Capture the accepted item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            key_reg  <= in_key;
            mode_reg <= in_mode;
        end
    end

    // Write port: clearing sweep or add/remove at the hashed position
    always_comb begin
        wr_en   = cmd.clr_step || cmd.wr_slot;
        wr_addr = cmd.clr_step ? clr_addr_reg : pos;
        wr_data = {(mode_reg == MODE_ADD) && !cmd.clr_step, key_reg};
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_read) begin
            rd_data_reg <= ring_mem[scan_addr_reg];
        end
    end

    // Advance the clearing address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
        end
    end

    // Walk the ring from the hashed position, wrapping at the end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.scan_read;
            if (cmd.scan_start) begin
                scan_cnt_reg <= '0;
            end else if (cmd.scan_read) begin
                scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_addr_reg <= pos;
        end else if (cmd.scan_read) begin
            if (scan_addr_reg == IDX_W'(RING_SIZE - 1)) begin
                scan_addr_reg <= '0;
            end else begin
                scan_addr_reg <= scan_addr_reg + IDX_W'(1);
            end
        end
    end

    // Hold the result until the output register is free
    always_ff @(posedge aclk) begin
        if (cmd.res_capture) begin
            unique case (cmd.res_sel)
                RES_ECHO: begin
                    res_server_reg <= key_reg;
                    res_found_reg  <= 1'b1;
                end
                RES_HIT: begin
                    res_server_reg <= rd_data_reg[KEY_W-1:0];
                    res_found_reg  <= 1'b1;
                end
                default: begin
                    res_server_reg <= '0;
                    res_found_reg  <= 1'b0;
                end
            endcase
        end
    end

    // Output register
    assign pos_wide = 32'(pos);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (out_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_server_reg <= res_server_reg;
            m_found_reg  <= res_found_reg;
            m_slot_reg   <= pos_wide[SLOT_W-1:0];
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_server = m_server_reg;
    assign out_found  = m_found_reg;
    assign out_slot   = m_slot_reg;

    // Status back to the controller
    always_comb begin
        status.mod_busy  = mod_busy;
        status.clr_last  = (clr_addr_reg == IDX_W'(RING_SIZE - 1));
        status.scan_hit  = rd_vld_reg && rd_data_reg[KEY_W];
        status.scan_done = (scan_cnt_reg == CNT_W'(RING_SIZE));
        status.out_free  = !m_valid_reg || out_ready;
        status.mode      = mode_reg;
    end

endmodule

`default_nettype wire

FILE: rtl/chr_ctrl.sv
`default_nettype none

module chr_ctrl
    import chr_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          in_valid,
    output logic         in_ready,
    input  chr_status_t  status,
    output chr_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_SCAN,
        ST_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Decode commands and next state
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.res_sel     = RES_MISS;
        in_ready        = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_HASH;
                end
            end
            ST_HASH: begin
                if (!status.mod_busy) begin
                    priority if (status.mode == MODE_LOOKUP) begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end else if (status.mode == MODE_ADD ||
                                 status.mode == MODE_REMOVE) begin
                        cmd.wr_slot     = 1'b1;
                        cmd.res_capture = 1'b1;
                        cmd.res_sel     = RES_ECHO;
                        state_next      = ST_RESULT;
                    end else begin
                        cmd.res_capture = 1'b1;
                        cmd.res_sel     = RES_MISS;
                        state_next      = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan_read = !status.scan_done;
                priority if (status.scan_hit) begin
                    cmd.res_capture = 1'b1;
                    cmd.res_sel     = RES_HIT;
                    state_next      = ST_RESULT;
                end else if (status.scan_done) begin
                    cmd.res_capture = 1'b1;
                    cmd.res_sel     = RES_MISS;
                    state_next      = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: bench/chr_ring_checker.sv
// Watches both channels of the hash ring, keeps its own copy of the ring and
// checks every result item against the prediction made when its item went in.
module chr_ring_checker
    import chr_pkg::*;
#(
    parameter int RING_SIZE = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,   // [63:0] key
    input  wire  [1:0]  s_tuser,   // [1:0] mode
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [71:0] m_tdata,   // [63:0] server_id, [68:64] slot, [71:69] zero
    input  wire         m_tuser,   // [0] found
    output int          fail_count,
    output int          replies_owed
);

    typedef struct packed {
        logic [KEY_W-1:0]  server_id;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } ring_reply_t;

    logic             slot_live  [RING_SIZE];
    logic [KEY_W-1:0] slot_owner [RING_SIZE];
    ring_reply_t      replies_due[$];

    always @(posedge aclk) begin
        logic [KEY_W-1:0] mix;
        int unsigned      pos;
        int unsigned      idx;
        ring_reply_t      want;
        if (!aresetn) begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            replies_due.delete();
            fail_count = 0;
        end else begin
            // compare the item leaving the block with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (replies_due.size() == 0) begin
                    $error("result item with no prediction pending: tdata %h tuser %b",
                           m_tdata, m_tuser);
                    fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (m_tdata[63:0] !== want.server_id) begin
                        $error("server_id: expected %h, got %h", want.server_id,
                               m_tdata[63:0]);
                        fail_count++;
                    end
                    if (m_tuser !== want.found) begin
                        $error("found: expected %b, got %b", want.found, m_tuser);
                        fail_count++;
                    end
                    if (m_tdata[68:64] !== want.slot) begin
                        $error("slot: expected %0d, got %0d", want.slot, m_tdata[68:64]);
                        fail_count++;
                    end
                end
            end

            // hash the accepted key, update the ring and queue its result
            if (s_tvalid && s_tready) begin
                mix = s_tdata;
                mix ^= mix << 13;
                mix ^= mix >> 17;
                mix ^= mix << 5;
                pos = 32'(mix % 64'(RING_SIZE));
                want.slot      = pos[SLOT_W-1:0];
                want.server_id = '0;
                want.found     = 1'b0;
                case (s_tuser)
                    MODE_ADD: begin
                        slot_live[pos]  = 1'b1;
                        slot_owner[pos] = s_tdata;
                        want.server_id  = s_tdata;
                        want.found      = 1'b1;
                    end
                    MODE_REMOVE: begin
                        slot_live[pos] = 1'b0;
                        want.server_id = s_tdata;
                        want.found     = 1'b1;
                    end
                    MODE_LOOKUP: begin
                        // walk clockwise from the key's slot, wrapping once
                        for (int i = 0; i < RING_SIZE; i++) begin
                            idx = (pos + i) % RING_SIZE;
                            if (!want.found && slot_live[idx]) begin
                                want.server_id = slot_owner[idx];
                                want.found     = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                replies_due.push_back(want);
            end
        end
        replies_owed <= replies_due.size();
    end

endmodule

FILE: bench/tb_consistent_hash_ring_core.sv
module tb_consistent_hash_ring_core;
    import chr_pkg::*;

    localparam int RING_SIZE  = 32;
    localparam int IDLE_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 1030;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    // The hash is linear and the top key bit only reaches hash bits 46 and up,
    // so flipping it keeps the ring position.
    localparam logic [KEY_W-1:0] SAME_SLOT_FLIP = 64'h8000_0000_0000_0000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;    // [63:0] key
    logic [1:0]  s_tuser;    // [1:0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [63:0] server_id, [68:64] slot, [71:69] zero
    logic        m_tuser;    // [0] found
    int          fail_count;
    int          replies_owed;
    int          calm_items;
    int          idle_cycles;

    consistent_hash_ring_core #(.RING_SIZE(RING_SIZE)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    chr_ring_checker #(.RING_SIZE(RING_SIZE)) ring_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .replies_owed (replies_owed)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic logic [KEY_W-1:0] any_key();
        return {$urandom(), $urandom()};
    endfunction

    // Offer one item, hold it until taken, then maybe go quiet for a while
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key);
        int pick;
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= mode;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (calm_items > 0) begin
            calm_items--;
        end else if (pick < 2) begin
            calm_items = $urandom_range(20, 60);
        end else if (pick < 60) begin
            gap = 0;
        end else if (pick < 88) begin
            gap = $urandom_range(1, 3);
        end else if (pick < 96) begin
            gap = $urandom_range(4, 10);
        end else begin
            gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold m_tready at one level for a random stretch
    task automatic sink_stretch(inout int ticks);
        int pick;
        int span;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            m_tready <= 1'b1;
            span = $urandom_range(60, 150);
        end else if (pick < 65) begin
            m_tready <= 1'b1;
            span = $urandom_range(1, 12);
        end else if (pick < 94) begin
            m_tready <= 1'b0;
            span = $urandom_range(1, 4);
        end else begin
            m_tready <= 1'b0;
            span = $urandom_range(20, 80);
        end
        repeat (span) @(posedge aclk);
        ticks += span;
    endtask

    // Result side: random stalls, plus one long hold-off that backs up the input
    initial begin : result_sink
        int ticks;
        m_tready <= 1'b0;
        ticks = 0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        while (ticks < 3000) sink_stretch(ticks);
        m_tready <= 1'b0;
        repeat (400) @(posedge aclk);
        forever sink_stretch(ticks);
    end

    // Abort when nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : item_source
        logic [KEY_W-1:0] servers[$];
        logic [KEY_W-1:0] key;
        int               sent;
        int               pick;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        s_tuser    <= MODE_ADD;
        calm_items = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty ring, extreme keys, replaced and foreign-removed slots
        send_item(MODE_LOOKUP, 64'h0);
        send_item(MODE_LOOKUP, '1);
        send_item(MODE_REMOVE, 64'd5);
        send_item(MODE_UNUSED, '1);
        send_item(MODE_ADD, 64'h0);
        send_item(MODE_ADD, '1);
        send_item(MODE_LOOKUP, 64'h0);
        send_item(MODE_ADD, SAME_SLOT_FLIP);
        send_item(MODE_LOOKUP, 64'h0);
        send_item(MODE_REMOVE, 64'h0);
        // only one server left: every lookup walks round to it
        repeat (4) send_item(MODE_LOOKUP, any_key());
        send_item(MODE_ADD, 64'h5555_5555_5555_5555);
        send_item(MODE_ADD, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(MODE_LOOKUP, 64'h1234_5678_9ABC_DEF0);
        send_item(MODE_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(MODE_UNUSED, 64'h0);
        send_item(MODE_REMOVE, '1);
        send_item(MODE_REMOVE, 64'h5555_5555_5555_5555);
        send_item(MODE_REMOVE, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(MODE_LOOKUP, any_key());

        // random traffic: servers come and go, lookups in between
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            // remove every tracked server now and then so sparse rings recur
            if (sent % 160 == 159) begin
                while (servers.size() > 0) begin
                    send_item(MODE_REMOVE, servers.pop_front());
                    sent++;
                end
            end
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                if (servers.size() > 0 && $urandom_range(0, 99) < 30)
                    key = servers[$urandom_range(0, servers.size() - 1)] ^ SAME_SLOT_FLIP;
                else
                    key = any_key();
                servers.push_back(key);
                if (servers.size() > 24) void'(servers.pop_front());
                send_item(MODE_ADD, key);
            end else if (pick < 55) begin
                if (servers.size() > 0 && $urandom_range(0, 99) < 80) begin
                    key = servers[0];
                    servers.delete(0);
                end else begin
                    key = any_key();
                end
                send_item(MODE_REMOVE, key);
            end else if (pick < 95) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    key = '0;
                else if (pick < 6)
                    key = '1;
                else
                    key = any_key();
                send_item(MODE_LOOKUP, key);
            end else begin
                send_item(MODE_UNUSED, any_key());
            end
            sent++;
        end
        s_tvalid <= 1'b0;

        // drain, then give stray results time to show up
        @(posedge aclk);
        while (replies_owed != 0) @(posedge aclk);
        repeat (RING_SIZE + 40) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/chr_pkg.sv
rtl/chr_posmod.sv
rtl/chr_dp.sv
rtl/chr_ctrl.sv
rtl/consistent_hash_ring_core.sv
bench/chr_ring_checker.sv
bench/tb_consistent_hash_ring_core.sv
